// File: rtl/core/ir_pulse_distance_encoder_unit_defines.svh
// Assertion macros for the IR pulse-distance encoder.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef IR_PULSE_DISTANCE_ENCODER_UNIT_DEFINES_SVH
`define IR_PULSE_DISTANCE_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define IPDE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define IPDE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define IPDE_ASSERT(name, prop, msg)
`define IPDE_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: rtl/core/ipde_pkg.sv
// Shared types and constants of the IR pulse-distance encoder.
// No dependencies; used by every module of the block.
package ipde_pkg;

  localparam int unsigned CFG_W       = 31;
  localparam int unsigned DUR_W       = 15;
  localparam int unsigned MARK_W      = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_FIRST_BIT = 4'd1;
  localparam logic [3:0] PH_LAST_BIT  = 4'd8;
  localparam logic [3:0] PH_FOOTER    = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER    = 3'd0,
    CFG_ONE       = 3'd1,
    CFG_ZERO      = 3'd2,
    CFG_FOOTER    = 3'd3,
    CFG_GAP       = 3'd4,
    CFG_REPEAT    = 3'd5,
    CFG_LOW_FIRST = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [DUR_W-1:0] space;
    logic [DUR_W-1:0] mark;
  } timing_t;

  typedef struct packed {
    timing_t          header;
    timing_t          one;
    timing_t          zero;
    timing_t          footer;
    logic [DUR_W-1:0] gap;
    logic [7:0]       repeat_cnt;
    logic             low_first;
  } cfg_t;

  // One byte of work for the symbol sequencer.
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       ftr;
    logic       use_gap;
    logic       tx_end;
  } desc_t;

endpackage

// File: rtl/core/ipde_front.sv
// Front end: accepts payload bytes, tracks frame start and repeat count.
// Depends on ipde_pkg; feeds descriptors into ipde_fifo.
module ipde_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipde_pkg::cfg_t     cfg_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               q_full_i,
  output logic               q_wr_o,
  output ipde_pkg::desc_t    q_data_o
);

  logic       at_start_q, at_start_d;
  logic [7:0] frames_q, frames_d;
  logic       more;
  logic       accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign q_wr_o = accept;
  assign more   = frames_q < cfg_i.repeat_cnt;

  always_comb begin
    q_data_o.data    = data_byte_i;
    q_data_o.hdr     = at_start_q && (cfg_i.header.mark != '0);
    q_data_o.ftr     = last_byte_i;
    q_data_o.use_gap = more && (cfg_i.gap != '0);
    q_data_o.tx_end  = last_byte_i && !more;

    at_start_d = at_start_q;
    frames_d   = frames_q;
    if (accept) begin
      at_start_d = last_byte_i;
      if (last_byte_i) begin
        frames_d = more ? frames_q + 8'd1 : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      frames_q   <= '0;
    end else begin
      at_start_q <= at_start_d;
      frames_q   <= frames_d;
    end
  end

endmodule

// File: rtl/core/ipde_fifo.sv
// Short descriptor queue between front end and symbol sequencer.
// Depends on ipde_pkg for the entry type and depth.
module ipde_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ipde_pkg::desc_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output ipde_pkg::desc_t rd_data_o,
  output logic            empty_o
);

  localparam int unsigned Depth = ipde_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ipde_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/core/ipde_back.sv
// Back end: header if flagged, eight bit symbols, footer if last, per descriptor.
// Depends on ipde_pkg and the assertion macros; drives the result register.
`include "ir_pulse_distance_encoder_unit_defines.svh"

module ipde_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipde_pkg::cfg_t                cfg_i,
  input  ipde_pkg::desc_t               q_data_i,
  input  logic                          q_empty_i,
  output logic                          q_rd_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [ipde_pkg::MARK_W-1:0]   mark_word_o,
  output logic [ipde_pkg::DUR_W-1:0]    space_word_o,
  output logic                          last_symbol_o,
  output logic                          transmission_end_o
);

  ipde_pkg::desc_t cur_q, cur_d;
  logic            busy_q, busy_d;
  logic [3:0]      phase_q, phase_d;

  logic                      out_valid_q, out_valid_d;
  logic [ipde_pkg::DUR_W-1:0] mark_q, mark_d;
  logic [ipde_pkg::DUR_W-1:0] space_q, space_d;
  logic                      last_q, last_d;
  logic                      tx_end_q, tx_end_d;

  logic       advance, emit, is_last, load;
  logic [2:0] bit_num, bit_pos;
  logic       bit_val;
  ipde_pkg::timing_t bit_timing;

  assign advance = !out_valid_q || pop;
  assign emit    = busy_q && advance;
  assign is_last = (phase_q == ipde_pkg::PH_FOOTER) ||
                   (phase_q == ipde_pkg::PH_LAST_BIT && !cur_q.ftr);
  // A queued descriptor is taken in the same cycle the previous one finishes.
  assign load    = (!busy_q || (emit && is_last)) && !q_empty_i;
  assign q_rd_o  = load;

  assign bit_num    = 3'(phase_q - ipde_pkg::PH_FIRST_BIT);
  assign bit_pos    = cfg_i.low_first ? bit_num : ~bit_num;  // ~b == 7 - b
  assign bit_val    = cur_q.data[bit_pos];
  assign bit_timing = bit_val ? cfg_i.one : cfg_i.zero;

  always_comb begin
    cur_d       = cur_q;
    busy_d      = busy_q;
    phase_d     = phase_q;
    mark_d      = mark_q;
    space_d     = space_q;
    last_d      = last_q;
    tx_end_d    = tx_end_q;
    out_valid_d = emit || (out_valid_q && !pop);

    if (emit) begin
      last_d   = is_last;
      tx_end_d = 1'b0;
      if (phase_q == ipde_pkg::PH_HEADER) begin
        mark_d  = cfg_i.header.mark;
        space_d = cfg_i.header.space;
      end else if (phase_q == ipde_pkg::PH_FOOTER) begin
        mark_d   = cfg_i.footer.mark;
        space_d  = cur_q.use_gap ? cfg_i.gap : cfg_i.footer.space;
        tx_end_d = cur_q.tx_end;
      end else begin
        mark_d  = bit_timing.mark;
        space_d = bit_timing.space;
      end
      phase_d = phase_q + 4'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end

    if (load) begin
      cur_d   = q_data_i;
      busy_d  = 1'b1;
      phase_d = q_data_i.hdr ? ipde_pkg::PH_HEADER : ipde_pkg::PH_FIRST_BIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= ipde_pkg::PH_HEADER;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    mark_q   <= mark_d;
    space_q  <= space_d;
    last_q   <= last_d;
    tx_end_q <= tx_end_d;
  end

  assign empty              = !out_valid_q;
  assign mark_word_o        = {1'b1, mark_q};
  assign space_word_o       = space_q;
  assign last_symbol_o      = last_q;
  assign transmission_end_o = tx_end_q;

  `IPDE_ASSERT(phase_in_range_a, busy_q |-> phase_q <= ipde_pkg::PH_FOOTER, "phase overran")
  `IPDE_ASSERT(footer_only_on_last_a,
               (busy_q && phase_q == ipde_pkg::PH_FOOTER) |-> cur_q.ftr,
               "footer without last byte")
  `IPDE_ASSERT(tx_end_is_last_a, (out_valid_q && tx_end_q) |-> last_q,
               "transmission end not on final symbol")
  `IPDE_ASSERT(load_when_free_a, q_rd_o |-> (!busy_q || (emit && is_last)),
               "descriptor taken while busy")
  `IPDE_ASSERT_ALWAYS(idle_after_reset_a, $rose(rst_ni) |-> (!busy_q && !out_valid_q),
                      "state not cleared in reset")

endmodule

// File: rtl/core/ir_pulse_distance_encoder_unit.sv
// IR pulse-distance encoder: payload bytes in, mark/space symbol pairs out.
// Channels: input queue side push/full with data_byte_i and last_byte_i; an item
//   is taken on a clock edge with push high and full low. Result side
//   empty/pop; the oldest symbol sits on mark_word_o, space_word_o,
//   last_symbol_o and transmission_end_o while empty is low, and leaves on an
//   edge with pop high.
// Each byte yields 8 to 10 symbols: optional header, eight bit symbols, footer
//   after a byte flagged last. The sequencer produces one symbol per cycle
//   while the output register is free or popped; the current-descriptor register
//   sits between queue and output. A two-entry descriptor queue decouples the
//   front end, so bytes are taken while earlier ones are still being sent.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i; index 7
//   is ignored. Write only while the block is idle.
// Reset clears control registers, empties the queue and output register, and arms
//   the next byte as a frame start. If the receiver stalls, the output register
//   holds, the sequencer waits, and full rises once the queue fills.
// Depends on ipde_pkg, ipde_front, ipde_fifo, ipde_back.
module ir_pulse_distance_encoder_unit #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipde_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ipde_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         data_byte_i,
  input  logic                               last_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [ipde_pkg::MARK_W-1:0]        mark_word_o,
  output logic [ipde_pkg::DUR_W-1:0]         space_word_o,
  output logic                               last_symbol_o,
  output logic                               transmission_end_o
);

  localparam logic [ipde_pkg::DUR_W-1:0] DurMask =
    ipde_pkg::DUR_W'((1 << DURATION_BITS) - 1);

  ipde_pkg::cfg_t    cfg_q, cfg_d;
  ipde_pkg::timing_t wr_timing;
  ipde_pkg::desc_t   fq_wr_data, fq_rd_data;
  logic              fq_wr, fq_rd, fq_full, fq_empty;

  assign wr_timing.mark  = cfg_wdata_i[14:0] & DurMask;
  assign wr_timing.space = cfg_wdata_i[30:16] & DurMask;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ipde_pkg::cfg_idx_e'(cfg_idx_i))
        ipde_pkg::CFG_HEADER:    cfg_d.header     = wr_timing;
        ipde_pkg::CFG_ONE:       cfg_d.one        = wr_timing;
        ipde_pkg::CFG_ZERO:      cfg_d.zero       = wr_timing;
        ipde_pkg::CFG_FOOTER:    cfg_d.footer     = wr_timing;
        ipde_pkg::CFG_GAP:       cfg_d.gap        = cfg_wdata_i[14:0] & DurMask;
        ipde_pkg::CFG_REPEAT:    cfg_d.repeat_cnt = cfg_wdata_i[7:0];
        ipde_pkg::CFG_LOW_FIRST: cfg_d.low_first  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ipde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (fq_full),
    .q_wr_o      (fq_wr),
    .q_data_o    (fq_wr_data)
  );

  ipde_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fq_wr),
    .wr_data_i (fq_wr_data),
    .full_o    (fq_full),
    .rd_i      (fq_rd),
    .rd_data_o (fq_rd_data),
    .empty_o   (fq_empty)
  );

  ipde_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_data_i           (fq_rd_data),
    .q_empty_i          (fq_empty),
    .q_rd_o             (fq_rd),
    .empty              (empty),
    .pop                (pop),
    .mark_word_o        (mark_word_o),
    .space_word_o       (space_word_o),
    .last_symbol_o      (last_symbol_o),
    .transmission_end_o (transmission_end_o)
  );

endmodule

// File: tb/ipde_symbol_checker.sv
`timescale 1ns / 100ps
// Symbol checker for the IR pulse-distance encoder: watches the register port and
// both queue sides, predicts the mark/space symbols of each accepted byte and compares.
// Depends on ipde_pkg.
module ipde_symbol_checker
  import ipde_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [MARK_W-1:0]    mark_word_o,
  input  logic [DUR_W-1:0]     space_word_o,
  input  logic                 last_symbol_o,
  input  logic                 transmission_end_o,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          symbols_due_o
);

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [DUR_W-1:0]  space;
    logic              last_sym;
    logic              tx_end;
  } symbol_t;

  // register copies, duration fields at 14:0 (mark) and 30:16 (space)
  logic [CFG_W-1:0] hdr_timing;
  logic [CFG_W-1:0] one_timing;
  logic [CFG_W-1:0] zero_timing;
  logic [CFG_W-1:0] ftr_timing;
  logic [DUR_W-1:0] gap_ticks;
  logic [7:0]       repeat_cnt;
  logic             low_first;

  logic             next_is_frame_start;
  logic [7:0]       frames_done;
  int unsigned      errors;
  symbol_t          symbols_due[$];

  function automatic symbol_t make_pair(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space);
    symbol_t s;
    s.mark     = {1'b1, mark};
    s.space    = space;
    s.last_sym = 1'b0;
    s.tx_end   = 1'b0;
    return s;
  endfunction

  function automatic void encode_byte(logic [7:0] byte_val, logic is_last);
    symbol_t          seq[10];
    int               n;
    int               pos;
    logic [CFG_W-1:0] t;
    logic             more;
    logic [DUR_W-1:0] ftr_space;
    n = 0;
    if (next_is_frame_start && hdr_timing[0 +: DUR_W] != '0) begin
      seq[n] = make_pair(hdr_timing[0 +: DUR_W], hdr_timing[16 +: DUR_W]);
      n++;
    end
    for (int b = 0; b < 8; b++) begin
      pos = low_first ? b : 7 - b;
      t = byte_val[pos] ? one_timing : zero_timing;
      seq[n] = make_pair(t[0 +: DUR_W], t[16 +: DUR_W]);
      n++;
    end
    if (is_last) begin
      // more repeats to come: gap replaces the footer space unless it is zero
      more = frames_done < repeat_cnt;
      ftr_space = (more && gap_ticks != '0) ? gap_ticks : ftr_timing[16 +: DUR_W];
      seq[n] = make_pair(ftr_timing[0 +: DUR_W], ftr_space);
      seq[n].tx_end = !more;
      frames_done = more ? frames_done + 8'd1 : 8'd0;
      n++;
    end
    next_is_frame_start = is_last;
    seq[n-1].last_sym = 1'b1;
    for (int i = 0; i < n; i++) symbols_due.push_back(seq[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    symbol_t got;
    symbol_t want;
    if (!rst_ni) begin
      hdr_timing          = '0;
      one_timing          = '0;
      zero_timing         = '0;
      ftr_timing          = '0;
      gap_ticks           = '0;
      repeat_cnt          = '0;
      low_first           = 1'b0;
      next_is_frame_start = 1'b1;
      frames_done         = '0;
      errors              = 0;
      symbols_due.delete();
      mismatch_cnt_o <= 0;
      symbols_due_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HEADER:    hdr_timing  = cfg_wdata_i;
          CFG_ONE:       one_timing  = cfg_wdata_i;
          CFG_ZERO:      zero_timing = cfg_wdata_i;
          CFG_FOOTER:    ftr_timing  = cfg_wdata_i;
          CFG_GAP:       gap_ticks   = cfg_wdata_i[DUR_W-1:0];
          CFG_REPEAT:    repeat_cnt  = cfg_wdata_i[7:0];
          CFG_LOW_FIRST: low_first   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got = '{mark_word_o, space_word_o, last_symbol_o, transmission_end_o};
        if (symbols_due.size() == 0) begin
          $error("unexpected symbol mark %h space %h", got.mark, got.space);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          if (got.mark !== want.mark) begin
            $error("mark_word expected %h got %h", want.mark, got.mark);
            errors++;
          end
          if (got.space !== want.space) begin
            $error("space_word expected %h got %h", want.space, got.space);
            errors++;
          end
          if (got.last_sym !== want.last_sym) begin
            $error("last_symbol expected %b got %b", want.last_sym, got.last_sym);
            errors++;
          end
          if (got.tx_end !== want.tx_end) begin
            $error("transmission_end expected %b got %b", want.tx_end, got.tx_end);
            errors++;
          end
        end
      end
      if (push && !full) encode_byte(data_byte_i, last_byte_i);
      symbols_due_o  <= symbols_due.size();
      mismatch_cnt_o <= errors;
    end
  end

endmodule

// File: tb/tb_ir_pulse_distance_encoder_unit.sv
`timescale 1ns / 100ps
// Testbench top of the IR pulse-distance encoder: clock, reset, register setup,
// byte requests and symbol pops under several idling patterns; verdict from ipde_symbol_checker.
// Depends on ipde_pkg, ir_pulse_distance_encoder_unit and ipde_symbol_checker.
module tb_ir_pulse_distance_encoder_unit;
  import ipde_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int                   HOLD_CYCLES    = 400;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [MARK_W-1:0]    mark_word_o;
  logic [DUR_W-1:0]     space_word_o;
  logic                 last_symbol_o;
  logic                 transmission_end_o;

  int unsigned mismatch_cnt;
  int unsigned symbols_due;
  int          send_idle_pct = 0;
  int          take_stall_pct = 0;
  logic        hold_go = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ir_pulse_distance_encoder_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .data_byte_i, .last_byte_i,
    .empty, .pop, .mark_word_o, .space_word_o, .last_symbol_o, .transmission_end_o
  );

  ipde_symbol_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .data_byte_i, .last_byte_i,
    .empty, .pop, .mark_word_o, .space_word_o, .last_symbol_o, .transmission_end_o,
    .mismatch_cnt_o(mismatch_cnt), .symbols_due_o(symbols_due)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] hdr, input logic [CFG_W-1:0] one,
                              input logic [CFG_W-1:0] zero, input logic [CFG_W-1:0] ftr,
                              input logic [DUR_W-1:0] gap, input logic [7:0] rep,
                              input logic lsb);
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_ONE, one);
    write_reg(CFG_ZERO, zero);
    write_reg(CFG_FOOTER, ftr);
    write_reg(CFG_GAP, CFG_W'(gap));
    write_reg(CFG_REPEAT, CFG_W'(rep));
    write_reg(CFG_LOW_FIRST, CFG_W'(lsb));
    // out-of-range index must leave every register alone
    write_reg(CFG_UNUSED_IDX, CFG_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input idling_e mode);
    send_idle_pct   = (mode == IDLE_SENDER) ? 81 : (mode == IDLE_BOTH) ? 7 : 0;
    take_stall_pct <= (mode == IDLE_RECEIVER) ? 81 : (mode == IDLE_BOTH) ? 7 : 0;
  endtask

  task automatic send_byte(input logic [7:0] val, input logic is_last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= val;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (full);
  endtask

  // every request accepted and every predicted symbol popped
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (symbols_due != 0);
  endtask

  // receiver: random stalls, plus one long hold-off so the input side backs up
  initial begin
    int hold_left = 0;
    bit hold_taken = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= take_stall_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] t_hdr;
    logic [CFG_W-1:0] t_one;
    logic [CFG_W-1:0] t_zero;
    logic [CFG_W-1:0] t_ftr;
    logic [DUR_W-1:0] t_gap;
    logic [7:0]       t_rep;
    logic             t_lsb;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // max header, bit 15 set in timings (masked), repeat once with the widest gap
    wait_idle();
    set_idling(IDLE_NONE);
    program_regs(31'h7FFF_FFFF, 31'h0123_8456, 31'h0001_0001, 31'h2222_B333,
                 15'h7FFF, 8'd1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);

    // zero header mark, LSB first, zero gap falls back to footer space
    wait_idle();
    program_regs(31'h1234_0000, 31'h0000_0000, 31'h7FFF_7FFF, 31'h4000_0001,
                 15'h0000, 8'd2, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hC3, 1'b1);

    // repeat count dropped below the frames already sent: next footer ends it
    wait_idle();
    write_reg(CFG_REPEAT, CFG_W'(8'd0));
    write_reg(CFG_GAP, CFG_W'(15'd1));
    cfg_we_i <= 1'b0;
    send_byte(8'h5A, 1'b1);
    send_byte(8'hE7, 1'b0);
    send_byte(8'h18, 1'b1);

    // largest repeat count
    wait_idle();
    program_regs(31'h0005_8000, 31'h0010_0020, 31'h0030_0040, 31'h0050_0060,
                 15'h0001, 8'd255, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h99, 1'b1);

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      if (p == 8) begin
        t_hdr = '0; t_one = '0; t_zero = '0; t_ftr = '0;
        t_gap = '0; t_rep = '0; t_lsb = 1'b0;
      end else if (p == 9) begin
        t_hdr = '1; t_one = '1; t_zero = '1; t_ftr = '1;
        t_gap = '1; t_rep = '1; t_lsb = 1'b1;
      end else begin
        t_hdr  = CFG_W'($urandom());
        t_one  = CFG_W'($urandom());
        t_zero = CFG_W'($urandom());
        t_ftr  = CFG_W'($urandom());
        if ($urandom_range(3) == 0) t_hdr[DUR_W-1:0] = '0;
        t_gap = ($urandom_range(2) == 0) ? '0 : DUR_W'($urandom_range(32767));
        t_rep = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        t_lsb = 1'($urandom_range(1));
      end
      program_regs(t_hdr, t_one, t_zero, t_ftr, t_gap, t_rep, t_lsb);
      set_idling((p == 1) ? IDLE_NONE : idling_e'(p % 4));
      if (p == 1) hold_go <= 1'b1;
      for (int i = 0; i < 30; i++) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && symbols_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ipde_pkg.sv
rtl/core/ipde_front.sv
rtl/core/ipde_fifo.sv
rtl/core/ipde_back.sv
rtl/core/ir_pulse_distance_encoder_unit.sv
tb/ipde_symbol_checker.sv
tb/tb_ir_pulse_distance_encoder_unit.sv
